// ===== hdl/rc_receiver_frame_decoder_assert.svh =====
// assertion macros shared by the decoder rtl
`ifndef RC_RECEIVER_FRAME_DECODER_ASSERT_SVH
`define RC_RECEIVER_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RCFD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RCFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rcfd_pkg.sv =====
`default_nettype none

package rcfd_pkg;

   localparam int FrameLen      = 16;
   localparam int HeaderLen     = 2;
   localparam int WordCount     = 7;
   localparam int ChanCount     = 8;
   localparam int ValWidth      = 10;
   localparam int SelWidth      = 3;
   localparam int PosWidth      = 4;
   localparam int ByteWidth     = 8;
   localparam int TickWidth     = 32;
   localparam int GapWidth      = 8;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 10;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CsrGapTicks         = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrModeLowThreshold  = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrModeHighThreshold = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrSwitchThreshold   = 3'd3;

   // register reset values
   localparam logic [GapWidth-1:0] GapTicksReset      = 8'd4;
   localparam logic [ValWidth-1:0] ModeLowReset       = 10'd400;
   localparam logic [ValWidth-1:0] ModeHighReset      = 10'd600;
   localparam logic [ValWidth-1:0] SwitchThreshReset  = 10'd500;

   // mode levels
   localparam logic [1:0] ModeLow  = 2'd0;
   localparam logic [1:0] ModeMid  = 2'd1;
   localparam logic [1:0] ModeHigh = 2'd2;

   typedef logic [ValWidth-1:0] chan_type;

   typedef struct packed {
      logic [ByteWidth-1:0] rx_byte;
      logic [TickWidth-1:0] tick_now;
   } req_type;

   typedef struct packed {
      chan_type             chan0;
      chan_type             chan1;
      chan_type             chan2;
      chan_type             chan3;
      chan_type             chan4;
      chan_type             chan5;
      chan_type             chan6;
      chan_type             chan7;
      logic [1:0]           mode_level;
      logic                 gear_on;
      logic                 mode_switch_on;
      logic [TickWidth-1:0] frames_seen;
   } rsp_type;

   typedef struct packed {
      logic [SelWidth-1:0] sel;
      chan_type            value;
   } word_type;

   typedef struct packed {
      logic                           vld;
      word_type [WordCount-1:0]       words;
   } frame_type;

   typedef struct packed {
      logic [GapWidth-1:0] gap_ticks;
      chan_type            mode_low_threshold;
      chan_type            mode_high_threshold;
      chan_type            switch_threshold;
   } config_type;

endpackage

`default_nettype wire

// ===== hdl/rcfd_assembler.sv =====
`default_nettype none

module rcfd_assembler import rcfd_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire req_type             req_payload,
   input  wire logic [GapWidth-1:0] gap_ticks,
   input  wire logic                dec_ready,
   output      frame_type           frame
);

   logic [TickWidth-1:0] last_tick_ff, last_tick_in;
   logic [PosWidth-1:0]  pos_ff, pos_in, pos_cur;
   logic [ByteWidth-1:0] rx_buf_ff [FrameLen];
   logic [ByteWidth-1:0] full_bytes [FrameLen];
   logic [TickWidth-1:0] tick_delta;
   logic                 accept, restart, done;
   logic                 frame_vld_ff, frame_vld_in;
   word_type [WordCount-1:0] words_ff, words_in;

   assign req_stall = frame_vld_ff & ~dec_ready;
   assign accept    = req_valid & ~req_stall;

   // modular difference, so tick wrap is harmless
   assign tick_delta = req_payload.tick_now - last_tick_ff;
   assign restart    = tick_delta >= TickWidth'(gap_ticks);
   assign pos_cur    = restart ? '0 : pos_ff;
   assign done       = pos_cur == PosWidth'(FrameLen - 1);

   always_comb begin
      for (int i = 0; i < FrameLen; i++) begin
         full_bytes[i] = rx_buf_ff[i];
      end
      // last byte of the frame is the one in this transfer
      full_bytes[FrameLen-1] = req_payload.rx_byte;
      for (int w = 0; w < WordCount; w++) begin
         words_in[w].sel   = full_bytes[HeaderLen + 2*w][ValWidth-ByteWidth +: SelWidth];
         words_in[w].value = {full_bytes[HeaderLen + 2*w][ValWidth-ByteWidth-1:0],
                              full_bytes[HeaderLen + 2*w + 1]};
      end
   end

   always_comb begin
      pos_in       = pos_ff;
      last_tick_in = last_tick_ff;
      if (accept) begin
         pos_in       = done ? '0 : pos_cur + PosWidth'(1);
         last_tick_in = req_payload.tick_now;
      end
      frame_vld_in = (accept & done) | (frame_vld_ff & ~dec_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         last_tick_ff <= '0;
         frame_vld_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         last_tick_ff <= last_tick_in;
         frame_vld_ff <= frame_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rx_buf_ff[pos_cur] <= req_payload.rx_byte;
      end
      if (accept && done) begin
         words_ff <= words_in;
      end
   end

   assign frame.vld   = frame_vld_ff;
   assign frame.words = words_ff;

endmodule

`default_nettype wire

// ===== hdl/rcfd_decoder.sv =====
`default_nettype none

module rcfd_decoder import rcfd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire frame_type  frame,
   input  wire config_type cfg,
   output      logic       dec_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      rsp_type    rsp_payload
);

   chan_type             chan_ff [ChanCount];
   chan_type             chan_in [ChanCount];
   logic [TickWidth-1:0] count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_payload_ff, rsp_payload_in;
   logic                 load;
   logic [1:0]           mode;

   assign dec_ready = ~rsp_valid_ff | ~rsp_stall;
   assign load      = frame.vld & dec_ready;

   // words apply in order, the last one naming a channel wins
   always_comb begin
      for (int k = 0; k < ChanCount; k++) begin
         chan_in[k] = chan_ff[k];
      end
      for (int w = 0; w < WordCount; w++) begin
         chan_in[frame.words[w].sel] = frame.words[w].value;
      end
      count_in = count_ff + TickWidth'(1);
   end

   always_comb begin
      priority if (chan_in[5] < cfg.mode_low_threshold) begin
         mode = ModeLow;
      end else if (chan_in[5] < cfg.mode_high_threshold) begin
         mode = ModeMid;
      end else begin
         mode = ModeHigh;
      end
   end

   always_comb begin
      rsp_payload_in.chan0          = chan_in[0];
      rsp_payload_in.chan1          = chan_in[1];
      rsp_payload_in.chan2          = chan_in[2];
      rsp_payload_in.chan3          = chan_in[3];
      rsp_payload_in.chan4          = chan_in[4];
      rsp_payload_in.chan5          = chan_in[5];
      rsp_payload_in.chan6          = chan_in[6];
      rsp_payload_in.chan7          = chan_in[7];
      rsp_payload_in.mode_level     = mode;
      rsp_payload_in.gear_on        = chan_in[4] > cfg.switch_threshold;
      rsp_payload_in.mode_switch_on = chan_in[6] > cfg.switch_threshold;
      rsp_payload_in.frames_seen    = count_in;
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ChanCount; k++) begin
            chan_ff[k] <= '0;
         end
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            for (int k = 0; k < ChanCount; k++) begin
               chan_ff[k] <= chan_in[k];
            end
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

// ===== hdl/rc_receiver_frame_decoder.sv =====
`default_nettype none

// Serial frame decoder for a radio control receiver. Each req transfer carries one
// received byte and the tick count at its arrival; a byte that comes gap_ticks or
// more after the previous one (modular difference) restarts the 16-byte frame. The
// block takes one byte every cycle unless req_stall is high. When the 16th byte of a
// frame is taken, its seven words are captured, and on the next free slot of the rsp
// register they update the eight stored channels; the frame's rsp transfer carries all
// channels, the mode level, the gear and mode switch flags and the frame count. Bytes
// keep flowing while a result waits in the rsp register; req_stall rises only when a
// second finished frame is waiting behind a stalled result. The user must write
// registers through the csr port while the block is idle, which it does not enforce:
// index 0 gap_ticks, 1 mode_low_threshold, 2 mode_high_threshold, 3 switch_threshold.
`include "rc_receiver_frame_decoder_assert.svh"

module rc_receiver_frame_decoder import rcfd_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_stall,
   input  wire req_type                  req_payload,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_stall,
   output      rsp_type                  rsp_payload,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data
);

   config_type cfg_ff, cfg_in;
   frame_type  frame;
   logic       dec_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CsrGapTicks:          cfg_in.gap_ticks           = csr_write_data[GapWidth-1:0];
            CsrModeLowThreshold:  cfg_in.mode_low_threshold  = csr_write_data[ValWidth-1:0];
            CsrModeHighThreshold: cfg_in.mode_high_threshold = csr_write_data[ValWidth-1:0];
            CsrSwitchThreshold:   cfg_in.switch_threshold    = csr_write_data[ValWidth-1:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gap_ticks           <= GapTicksReset;
         cfg_ff.mode_low_threshold  <= ModeLowReset;
         cfg_ff.mode_high_threshold <= ModeHighReset;
         cfg_ff.switch_threshold    <= SwitchThreshReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcfd_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .gap_ticks   (cfg_ff.gap_ticks),
      .dec_ready   (dec_ready),
      .frame       (frame)
   );

   rcfd_decoder u_decoder (
      .clock       (clock),
      .reset       (reset),
      .frame       (frame),
      .cfg         (cfg_ff),
      .dec_ready   (dec_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // a new result only ever comes from a captured frame
   `RCFD_ASSERT_NOW(a_rsp_from_frame, $rose(rsp_valid), $past(frame.vld), "result without frame")

   // with a zero gap every byte restarts, so no frame can complete
   `RCFD_ASSERT_NEXT(a_zero_gap_no_frame,
      req_valid && !req_stall && cfg_ff.gap_ticks == '0, !frame.vld,
      "frame completed with zero gap")

   // a captured frame never waits when the result register can take it
   `RCFD_ASSERT_NEXT(a_frame_drains, frame.vld && dec_ready, rsp_valid,
      "captured frame not moved to result")

endmodule

`default_nettype wire
